@@ rtl/core/bsfdc8_pkg.sv @@
// ----------------------------------------------------------------------------
// bsfdc8_pkg
// Shared types, constants and the CRC-8 byte step for the frame deframer.
// ----------------------------------------------------------------------------
package bsfdc8_pkg;

  localparam int          EXP_W     = 9;        // length byte + 2
  localparam logic [3:0]  BYTE_BITS = 4'd8;
  localparam logic [7:0]  CRC_POLY  = 8'h9B;
  localparam logic [7:0]  CRC_INIT  = 8'h00;

  typedef enum logic [5:0] {
    ST_HUNT     = 6'b000001,
    ST_FRAME    = 6'b000010,
    ST_CHK_ADDR = 6'b000100,
    ST_CHK_DATA = 6'b001000,
    ST_EMT_ADDR = 6'b010000,
    ST_EMT_DATA = 6'b100000
  } state_t;

  // CRC-8 over one byte, MSB first, no final XOR
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    r = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/core/bit_stream_frame_deframer_crc8_top.sv @@
// ----------------------------------------------------------------------------
// bit_stream_frame_deframer_crc8_top
// Length-prefixed bit-stream deframer with CRC-8 (poly 0x9B) frame check.
// ----------------------------------------------------------------------------
//
//  channel  handshake             payload                    direction
//  -------  --------------------  -------------------------  ---------
//  in       in_valid / in_stall   data_bit, sync_flag        into block
//  out      out_valid / out_stall payload_byte, last_byte    out of block
//  cfg      cfg_valid / cfg_ready cfg_data (crc_check_enable) into block
//
//  Cycles: while hunting for sync or collecting a frame, one bit transfer per
//  cycle. After the bit that closes the frame the input stalls: with checking
//  on, the CRC walk reads each stored byte through CHK_ADDR then CHK_DATA (one
//  RAM read port, one shared CRC byte unit), then the payload walk moves each
//  byte through EMT_ADDR then EMT_DATA, held by output stalls. The block resumes
//  hunting as soon as the final byte sits in the output register. Reset (rst,
//  synchronous) clears control state only; the frame store has no clearing
//  pass, since every entry read was written this frame.
//
module bit_stream_frame_deframer_crc8_top
  import bsfdc8_pkg::*;
#(
  parameter int FRAME_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       data_bit,
  input  logic       sync_flag,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] payload_byte,
  output logic       last_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  localparam int            PW      = $clog2(FRAME_BYTES);
  localparam logic [PW-1:0] POS_MAX = PW'(FRAME_BYTES - 1);

  state_t           state;
  logic             crc_check_enable;
  logic [3:0]       bits_in_byte;
  logic [PW-1:0]    byte_position;
  logic [EXP_W-1:0] expected_total;
  logic [7:0]       shift_reg;
  logic [7:0]       len_byte;
  logic [PW-1:0]    end_idx;   // index of the last byte still to check or emit
  logic [PW-1:0]    cnt;       // walk index, also the RAM read address
  logic [7:0]       crc;

  logic             in_accept;
  logic             take;
  logic             out_free;
  logic [3:0]       bits_next;
  logic [PW-1:0]    pos_next;
  logic [EXP_W-1:0] exp_next;
  logic [7:0]       byte_next;
  logic             byte_done;
  logic             frame_end;
  logic [7:0]       ram_q;

  // Take bits only while hunting or collecting; the user writes config only idle (not enforced here).
  assign in_stall  = !(state inside {ST_HUNT, ST_FRAME});
  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;
  // A frame starts on a sync transfer; inside a frame every bit is data.
  assign take      = in_accept && (state == ST_FRAME || sync_flag);
  assign out_free  = !out_valid || !out_stall;

  // Bit packer: advance the byte counter, refresh the expected size when the
  // length byte has just completed, shift the new bit in MSB first.
  always_comb begin
    bits_next = bits_in_byte;
    pos_next  = byte_position;
    if (state == ST_HUNT) begin
      bits_next = '0;
      pos_next  = '0;
    end
    if (bits_next >= BYTE_BITS) begin
      bits_next = '0;
      if (pos_next != POS_MAX) begin
        pos_next = pos_next + 1'b1;
      end
    end
    exp_next = expected_total;
    if (pos_next == PW'(1) && bits_next == 4'd0) begin
      exp_next = {1'b0, len_byte} + EXP_W'(1) + EXP_W'(crc_check_enable);
    end
    byte_next = (bits_next == 4'd0) ? {7'b0, data_bit} : {shift_reg[6:0], data_bit};
    bits_next = bits_next + 4'd1;
    byte_done = (bits_next == BYTE_BITS);
    // Close on the declared size (never on byte 0) or on a full store.
    frame_end = (state == ST_FRAME) && byte_done &&
                ((pos_next != '0 && (EXP_W'(pos_next) + EXP_W'(1)) == exp_next) ||
                 pos_next == POS_MAX);
  end

  bsfdc8_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (take && byte_done),
    .waddr (pos_next),
    .wdata (byte_next),
    .raddr (cnt),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_HUNT;
      crc_check_enable <= 1'b1;
      bits_in_byte     <= '0;
      byte_position    <= '0;
      expected_total   <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        crc_check_enable <= cfg_data;
      end
      // Drop the output once its transfer completes; a reload below wins.
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_HUNT: begin
          if (take) begin
            bits_in_byte  <= bits_next;
            byte_position <= pos_next;
            shift_reg     <= byte_next;
            state         <= ST_FRAME;
          end
        end
        ST_FRAME: begin
          if (in_accept) begin
            bits_in_byte   <= bits_next;
            byte_position  <= pos_next;
            expected_total <= exp_next;
            shift_reg      <= byte_next;
            if (byte_done && pos_next == '0) begin
              len_byte <= byte_next;
            end
            if (frame_end) begin
              end_idx <= pos_next;
              crc     <= CRC_INIT;
              if (crc_check_enable) begin
                cnt   <= '0;
                state <= ST_CHK_ADDR;
              end else begin
                cnt   <= PW'(1);
                state <= ST_EMT_ADDR;
              end
            end
          end
        end
        ST_CHK_ADDR: begin
          state <= ST_CHK_DATA;
        end
        ST_CHK_DATA: begin
          if (cnt == end_idx) begin
            // Last stored byte holds the CRC; drop the frame on mismatch or with no payload.
            if (ram_q != crc || end_idx == PW'(1)) begin
              state <= ST_HUNT;
            end else begin
              end_idx <= end_idx - 1'b1;
              cnt     <= PW'(1);
              state   <= ST_EMT_ADDR;
            end
          end else begin
            crc   <= crc8_byte(crc, ram_q);
            cnt   <= cnt + 1'b1;
            state <= ST_CHK_ADDR;
          end
        end
        ST_EMT_ADDR: begin
          // Hold the read until the output register is free at this edge.
          if (out_free) begin
            state <= ST_EMT_DATA;
          end
        end
        ST_EMT_DATA: begin
          payload_byte <= ram_q;
          last_byte    <= (cnt == end_idx);
          out_valid    <= 1'b1;
          if (cnt == end_idx) begin
            state <= ST_HUNT;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= ST_EMT_ADDR;
          end
        end
        default: begin
          state <= ST_HUNT;
        end
      endcase
    end
  end

  // Loading the output never overwrites a byte still waiting for transfer.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMT_DATA |-> !out_valid)
    else $error("output register reloaded while occupied");

  // Emitted indices skip the length byte and stay inside the frame.
  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMT_DATA |-> (cnt != '0 && cnt <= end_idx))
    else $error("emit index out of frame range");

  // After the final payload byte the block goes back to hunting.
  a_last_to_hunt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMT_DATA && cnt == end_idx) |=> state == ST_HUNT)
    else $error("no return to hunt after last byte");

  // A result only appears from the emit walk.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EMT_DATA))
    else $error("output valid raised outside emit");

endmodule

@@ rtl/core/bsfdc8_ram.sv @@
// ----------------------------------------------------------------------------
// bsfdc8_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module bsfdc8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
